// File: hw/rtl/ism_pkg.sv
// Shared constants, item types and state codes of the Ising spin-flip block.
package ism_pkg;

	localparam int ROWS = 32;
	localparam int COLS = 32;
	localparam int ROW_W = $clog2(ROWS);
	localparam int COL_W = $clog2(COLS);
	localparam int SITES = ROWS * COLS;
	localparam int ADDR_W = $clog2(SITES);

	// Widths of the item fields.
	localparam int POS_W = 5;
	localparam int Q_W = 32;
	localparam int J_W = 5;
	localparam int ENERGY_W = 16;
	// Wide enough to compare a row or column field against a lattice size of up to 256.
	localparam int LIM_W = 9;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_COUPLING = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_LOW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_HIGH = 2'd2;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ = 2'd1,
		OP_TRIAL = 2'd2,
		OP_RECOMPUTE = 2'd3
	} op_t;

	typedef struct packed {
		op_t operation;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic spin_value;
		logic [Q_W-1:0] random_value;
	} in_item_t;

	typedef struct packed {
		logic accepted;
		logic spin_out;
		logic signed [ENERGY_W-1:0] energy;
	} out_item_t;

	typedef struct packed {
		logic signed [J_W-1:0] coupling;
		logic [Q_W-1:0] thr_low;
		logic [Q_W-1:0] thr_high;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_RD_WAIT,
		ST_TR_READ,
		ST_TR_DECIDE,
		ST_RC,
		ST_DONE
	} core_state_t;

endpackage

// File: hw/rtl/ism_ram.sv
// Generic single-port synchronous RAM with a registered read.
module ism_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (en) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/ism_core.sv
// Sequencer and arithmetic for the lattice operations around the spin memory.
module ism_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ism_pkg::in_item_t item,
	input  ism_pkg::cfg_t     cfg,
	input  logic              out_free,
	output logic              done,
	output ism_pkg::out_item_t result
);

	function automatic logic [ism_pkg::ROW_W-1:0] row_prev(input logic [ism_pkg::ROW_W-1:0] r);
		return (r == '0) ? ism_pkg::ROW_W'(ism_pkg::ROWS - 1) : r - 1'b1;
	endfunction

	function automatic logic [ism_pkg::ROW_W-1:0] row_next(input logic [ism_pkg::ROW_W-1:0] r);
		return (r == ism_pkg::ROW_W'(ism_pkg::ROWS - 1)) ? '0 : r + 1'b1;
	endfunction

	function automatic logic [ism_pkg::COL_W-1:0] col_prev(input logic [ism_pkg::COL_W-1:0] c);
		return (c == '0) ? ism_pkg::COL_W'(ism_pkg::COLS - 1) : c - 1'b1;
	endfunction

	function automatic logic [ism_pkg::COL_W-1:0] col_next(input logic [ism_pkg::COL_W-1:0] c);
		return (c == ism_pkg::COL_W'(ism_pkg::COLS - 1)) ? '0 : c + 1'b1;
	endfunction

	function automatic logic [ism_pkg::ADDR_W-1:0] site(input logic [ism_pkg::ROW_W-1:0] r,
			input logic [ism_pkg::COL_W-1:0] c);
		return ism_pkg::ADDR_W'(int'(r) * ism_pkg::COLS + int'(c));
	endfunction

	ism_pkg::core_state_t state_q, state_d;

	ism_pkg::in_item_t item_q;
	logic inside_q;
	logic [ism_pkg::ROW_W-1:0] r_q;
	logic [ism_pkg::COL_W-1:0] c_q;

	logic [2:0] tstep_q;
	logic center_q;
	logic [2:0] eq_q;

	logic [1:0] ph_q;
	logic [ism_pkg::ROW_W-1:0] wr_q;
	logic [ism_pkg::COL_W-1:0] wc_q;
	logic s_q, d_q;
	logic signed [ism_pkg::ENERGY_W-1:0] acc_q;
	logic signed [ism_pkg::ENERGY_W-1:0] energy_q;

	logic res_acc_q, res_spin_q;

	logic ram_en, ram_we, ram_wdata, ram_rdata;
	logic [ism_pkg::ADDR_W-1:0] ram_addr;

	logic inside_in;
	logic signed [ism_pkg::ENERGY_W-1:0] jx, de, term, acc_next;
	logic de_pos, take, walk_last;
	logic [ism_pkg::Q_W-1:0] thr;
	logic [1:0] eq2;

	assign inside_in = (ism_pkg::LIM_W'(item.row) < ism_pkg::LIM_W'(ism_pkg::ROWS))
		&& (ism_pkg::LIM_W'(item.col) < ism_pkg::LIM_W'(ism_pkg::COLS));

	// Flipping the centre spin costs dE = 2*J*s*sum; with e neighbours equal to the centre
	// that is J*(4e - 8), built from shifts of the sign-extended coupling.
	assign jx = {{(ism_pkg::ENERGY_W - ism_pkg::J_W){cfg.coupling[ism_pkg::J_W-1]}}, cfg.coupling};

	always_comb begin
		case (eq_q)
			3'd0: de = -(jx <<< 3);
			3'd1: de = -(jx <<< 2);
			3'd2: de = '0;
			3'd3: de = jx <<< 2;
			default: de = jx <<< 3;
		endcase
	end

	assign de_pos = !de[ism_pkg::ENERGY_W-1] && (de != '0);
	// All four neighbours agree exactly when none or all of them match the centre.
	assign thr = (eq_q == 3'd0 || eq_q == 3'd4) ? cfg.thr_high : cfg.thr_low;
	assign take = de_pos ? (item_q.random_value <= thr) : 1'b1;

	// Bond energy of one site with its lower and right neighbours: -J*s*(sd + sr).
	assign eq2 = 2'(s_q == d_q) + 2'(s_q == ram_rdata);
	always_comb begin
		case (eq2)
			2'd0: term = -(jx <<< 1);
			2'd1: term = '0;
			default: term = jx <<< 1;
		endcase
	end
	assign acc_next = acc_q - term;

	assign walk_last = (wr_q == ism_pkg::ROW_W'(ism_pkg::ROWS - 1))
		&& (wc_q == ism_pkg::COL_W'(ism_pkg::COLS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ism_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ram_en = 1'b0;
		ram_we = 1'b0;
		ram_addr = site(r_q, c_q);
		ram_wdata = item_q.spin_value;
		done = 1'b0;
		busy = 1'b1;
		case (state_q)
			ism_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = ism_pkg::ST_DISPATCH;
				end
			end
			ism_pkg::ST_DISPATCH: begin
				case (item_q.operation)
					ism_pkg::OP_WRITE: begin
						ram_we = inside_q;
						state_d = ism_pkg::ST_DONE;
					end
					ism_pkg::OP_READ: begin
						ram_en = inside_q;
						state_d = inside_q ? ism_pkg::ST_RD_WAIT : ism_pkg::ST_DONE;
					end
					ism_pkg::OP_TRIAL: begin
						ram_en = inside_q;
						state_d = inside_q ? ism_pkg::ST_TR_READ : ism_pkg::ST_DONE;
					end
					default: begin
						state_d = ism_pkg::ST_RC;
					end
				endcase
			end
			ism_pkg::ST_RD_WAIT: begin
				state_d = ism_pkg::ST_DONE;
			end
			ism_pkg::ST_TR_READ: begin
				// Step k issues neighbour k while the data of step k-1 comes back.
				ram_en = (tstep_q <= 3'd4);
				case (tstep_q)
					3'd1: ram_addr = site(row_prev(r_q), c_q);
					3'd2: ram_addr = site(row_next(r_q), c_q);
					3'd3: ram_addr = site(r_q, col_prev(c_q));
					default: ram_addr = site(r_q, col_next(c_q));
				endcase
				if (tstep_q == 3'd5) begin
					state_d = ism_pkg::ST_TR_DECIDE;
				end
			end
			ism_pkg::ST_TR_DECIDE: begin
				ram_we = take;
				ram_wdata = !center_q;
				state_d = ism_pkg::ST_DONE;
			end
			ism_pkg::ST_RC: begin
				case (ph_q)
					2'd0: begin
						ram_en = 1'b1;
						ram_addr = site(wr_q, wc_q);
					end
					2'd1: begin
						ram_en = 1'b1;
						ram_addr = site(row_next(wr_q), wc_q);
					end
					2'd2: begin
						ram_en = 1'b1;
						ram_addr = site(wr_q, col_next(wc_q));
					end
					default: begin
						if (walk_last) begin
							state_d = ism_pkg::ST_DONE;
						end
					end
				endcase
			end
			ism_pkg::ST_DONE: begin
				done = 1'b1;
				if (out_free) begin
					state_d = ism_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ism_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q <= '0;
			tstep_q <= '0;
			ph_q <= '0;
			wr_q <= '0;
			wc_q <= '0;
		end else begin
			case (state_q)
				ism_pkg::ST_DISPATCH: begin
					tstep_q <= 3'd1;
					ph_q <= '0;
					wr_q <= '0;
					wc_q <= '0;
				end
				ism_pkg::ST_TR_READ: begin
					tstep_q <= tstep_q + 3'd1;
				end
				ism_pkg::ST_TR_DECIDE: begin
					if (take) begin
						energy_q <= energy_q + de;
					end
				end
				ism_pkg::ST_RC: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd3) begin
						if (wc_q == ism_pkg::COL_W'(ism_pkg::COLS - 1)) begin
							wc_q <= '0;
							wr_q <= row_next(wr_q);
						end else begin
							wc_q <= wc_q + 1'b1;
						end
						if (walk_last) begin
							energy_q <= acc_next;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ism_pkg::ST_IDLE: begin
				if (start) begin
					item_q <= item;
					inside_q <= inside_in;
					r_q <= ism_pkg::ROW_W'(item.row);
					c_q <= ism_pkg::COL_W'(item.col);
				end
			end
			ism_pkg::ST_DISPATCH: begin
				res_acc_q <= 1'b0;
				res_spin_q <= (item_q.operation == ism_pkg::OP_WRITE)
					&& inside_q && item_q.spin_value;
				eq_q <= '0;
				acc_q <= '0;
			end
			ism_pkg::ST_RD_WAIT: begin
				res_spin_q <= ram_rdata;
			end
			ism_pkg::ST_TR_READ: begin
				if (tstep_q == 3'd1) begin
					center_q <= ram_rdata;
				end else begin
					eq_q <= eq_q + 3'(ram_rdata == center_q);
				end
			end
			ism_pkg::ST_TR_DECIDE: begin
				res_acc_q <= take;
				res_spin_q <= center_q ^ take;
			end
			ism_pkg::ST_RC: begin
				case (ph_q)
					2'd1: begin
						s_q <= ram_rdata;
						// The walk passes the addressed site once; its spin goes out with the result.
						if (wr_q == r_q && wc_q == c_q) begin
							res_spin_q <= ram_rdata;
						end
					end
					2'd2: d_q <= ram_rdata;
					2'd3: acc_q <= acc_next;
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	assign result.accepted = res_acc_q;
	assign result.spin_out = res_spin_q;
	assign result.energy = energy_q;

	ism_ram #(
		.WIDTH(1),
		.DEPTH(ism_pkg::SITES)
	) u_lattice (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// The lattice is written only by a spin write or by the decision of a trial.
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ism_pkg::ST_DISPATCH || state_q == ism_pkg::ST_TR_DECIDE))
		else $error("lattice written outside a write or trial decision");

	// A finished result waits in DONE until the output register can take it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ism_pkg::ST_DONE && !out_free) |=> (state_q == ism_pkg::ST_DONE))
		else $error("result dropped while output register was full");

	// The running energy moves only on a trial decision or at the end of the walk.
	assert property (@(posedge clk) disable iff (!arst_n)
		(energy_q != $past(energy_q)) |->
		($past(state_q) == ism_pkg::ST_TR_DECIDE || $past(state_q) == ism_pkg::ST_RC))
		else $error("energy changed outside a trial or recompute");

endmodule

// File: hw/rtl/ising_metropolis_spin_flip_top.sv
// Top level of the Ising spin-flip block: configuration registers, output register, core.
//
// A periodic ROWS x COLS lattice of one-bit spins lives in a single-port memory that
// returns one bit per cycle, and every operation is sequenced over that one port, one
// transaction at a time. A write stores one spin, a read fetches one, a Metropolis trial
// makes five single-bit reads and then the decision and write-back, and a recompute walks
// the whole lattice, reading each site and its lower and right neighbours in turn. A result
// waits in an output register; the next item is taken once the core has handed its result
// over. The lattice has no reset and must be written in full before trials or a recompute.
module ising_metropolis_spin_flip_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  ism_pkg::in_item_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output ism_pkg::out_item_t                  out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ism_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ism_pkg::Q_W-1:0]             cfg_data
);

	ism_pkg::cfg_t cfg_q;
	ism_pkg::out_item_t out_data_q, result;
	logic out_valid_q, out_free, done, busy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coupling <= ism_pkg::J_W'(1);
			cfg_q.thr_low <= '0;
			cfg_q.thr_high <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ism_pkg::CFG_COUPLING: cfg_q.coupling <= cfg_data[ism_pkg::J_W-1:0];
				ism_pkg::CFG_THR_LOW: cfg_q.thr_low <= cfg_data;
				ism_pkg::CFG_THR_HIGH: cfg_q.thr_high <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done && out_free) begin
			out_data_q <= result;
		end
	end

	assign in_stall = busy;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	ism_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_valid),
		.busy    (busy),
		.item    (in_data),
		.cfg     (cfg_q),
		.out_free(out_free),
		.done    (done),
		.result  (result)
	);

endmodule
